>>> rtl/bmhq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared operation codes, status codes and controller interface types for
// the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_APPEND  = 2'd2,
    OP_BUILD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  localparam int unsigned CountWidth = 11;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP      = 4'd0,
    DP_START    = 4'd1,  // latch the operation and key
    DP_APPEND   = 4'd2,  // write key at the end, count up
    DP_RD_LAST  = 4'd3,  // read last entry, count down
    DP_ROOT_WR  = 4'd4,  // write last entry to the root
    DP_RD_A     = 4'd5,  // read entry at position
    DP_RD_B     = 4'd6,  // read parent or left child
    DP_RD_C     = 4'd7,  // read right child
    DP_SWAP_1   = 4'd8,  // write first half of a swap
    DP_SWAP_2   = 4'd9,  // write second half of a swap
    DP_BLD_INIT = 4'd10, // set the build index
    DP_BLD_NEXT = 4'd11, // step the build index down
    DP_RD_ROOT  = 4'd12, // read the root for the result
    DP_DONE     = 4'd13  // load the result register
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
  } dp_ctl_t;

  typedef struct packed {
    logic    is_full;
    logic    is_empty;
    logic    at_root;      // sift position is zero
    logic    up_swap;      // parent strictly larger than position
    logic    has_left;     // left child exists
    logic    has_right;    // right child exists
    logic    down_swap;    // a strictly smaller child exists
    logic    bld_last;     // build index reached zero
    op_e     op;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/bmhq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One access per cycle; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

>>> rtl/bmhq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_datapath
// Key store, count, sift position and compare logic of the heap queue.
// ----------------------------------------------------------------------------
module bmhq_datapath #(
  parameter int unsigned Capacity = 1024,
  parameter int unsigned KeyWidth = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bmhq_pkg::dp_ctl_t                 ctl_i,
  output bmhq_pkg::dp_sts_t                      sts_o,
  input  wire logic [1:0]                        func_i,
  input  wire logic [KeyWidth-1:0]               key_in_i,
  output logic      [KeyWidth-1:0]               taken_key_o,
  output logic      [KeyWidth-1:0]               min_key_o,
  output logic      [bmhq_pkg::CountWidth-1:0]   entry_count_o,
  output logic      [1:0]                        status_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned NW = AW + 2;  // holds 2*pos+2 and the capacity

  logic [KeyWidth-1:0] rdata;
  logic                we;
  logic [AW-1:0]       addr;
  logic [KeyWidth-1:0] wdata;

  logic [NW-1:0]       cnt_q, cnt_d;
  logic [NW-1:0]       pos_q, pos_d;
  logic [NW-1:0]       bld_q, bld_d;
  logic [NW-1:0]       tgt_q, tgt_d;
  logic [KeyWidth-1:0] key_q, key_d;
  logic [KeyWidth-1:0] ka_q, ka_d;   // key at position
  logic [KeyWidth-1:0] kb_q, kb_d;   // parent or best child key
  logic [KeyWidth-1:0] tk_q, tk_d;
  bmhq_pkg::op_e       op_q, op_d;
  logic [1:0]          st_q, st_d;
  logic                rb_q, rb_d;   // the b-read compares in right child

  logic [NW-1:0] parent, left, right;
  logic [NW-1:0] cnt_m1;

  assign parent = (pos_q - NW'(1)) >> 1;
  assign left   = {pos_q[NW-2:0], 1'b1};
  assign right  = left + NW'(1);
  assign cnt_m1 = cnt_q - NW'(1);

  bmhq_ram #(.Width(KeyWidth), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // Command decode: memory access and register updates.
  always_comb begin
    we    = 1'b0;
    addr  = pos_q[AW-1:0];
    wdata = ka_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    bld_d = bld_q;
    tgt_d = tgt_q;
    key_d = key_q;
    ka_d  = ka_q;
    kb_d  = kb_q;
    tk_d  = tk_q;
    op_d  = op_q;
    st_d  = st_q;
    rb_d  = rb_q;
    unique case (ctl_i.cmd)
      bmhq_pkg::DP_START: begin
        op_d  = bmhq_pkg::op_e'(func_i);
        key_d = key_in_i;
        tk_d  = '0;
        st_d  = bmhq_pkg::ST_OK;
      end
      bmhq_pkg::DP_APPEND: begin
        if (cnt_q >= NW'(Capacity)) begin
          st_d = bmhq_pkg::ST_FULL;
        end else begin
          we    = 1'b1;
          addr  = cnt_q[AW-1:0];
          wdata = key_q;
          ka_d  = key_q;
          pos_d = cnt_q;
          cnt_d = cnt_q + NW'(1);
        end
      end
      bmhq_pkg::DP_RD_LAST: begin
        if (cnt_q == '0) begin
          st_d = bmhq_pkg::ST_EMPTY;
        end else begin
          addr  = cnt_m1[AW-1:0];
          cnt_d = cnt_m1;
          pos_d = '0;
          tk_d  = min_key_o;
        end
      end
      bmhq_pkg::DP_ROOT_WR: begin
        we    = 1'b1;
        addr  = '0;
        wdata = rdata;
      end
      bmhq_pkg::DP_RD_A: begin
        addr = pos_q[AW-1:0];
      end
      bmhq_pkg::DP_RD_B: begin
        // Capture the position key, then read parent or left child.
        ka_d = rdata;
        rb_d = 1'b0;
        if (op_q == bmhq_pkg::OP_INSERT) begin
          addr  = parent[AW-1:0];
          tgt_d = parent;
        end else begin
          addr  = left[AW-1:0];
          tgt_d = left;
        end
      end
      bmhq_pkg::DP_RD_C: begin
        // Left child key arrives and is held as the best so far; read the right child.
        kb_d = rdata;
        rb_d = 1'b1;
        addr = right[AW-1:0];
      end
      bmhq_pkg::DP_SWAP_1: begin
        // Resolve right child compare, then write winner key at position.
        if (rb_q && sts_o.has_right && (rdata < kb_q)) begin
          kb_d  = rdata;
          tgt_d = right;
          we    = 1'b1;
          addr  = pos_q[AW-1:0];
          wdata = rdata;
        end else begin
          we    = 1'b1;
          addr  = pos_q[AW-1:0];
          wdata = rb_q ? kb_q : rdata;
        end
        rb_d = 1'b0;
      end
      bmhq_pkg::DP_SWAP_2: begin
        we    = 1'b1;
        addr  = tgt_q[AW-1:0];
        wdata = ka_q;
        pos_d = tgt_q;
      end
      bmhq_pkg::DP_BLD_INIT: begin
        bld_d = cnt_q >> 1;
        pos_d = cnt_q >> 1;
      end
      bmhq_pkg::DP_BLD_NEXT: begin
        bld_d = bld_q - NW'(1);
        pos_d = bld_q - NW'(1);
      end
      bmhq_pkg::DP_RD_ROOT: begin
        addr = '0;
      end
      bmhq_pkg::DP_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Compare results for the controller.
  logic down_cmp;
  always_comb begin
    // At DP_SWAP_1 decision point the right child data is on rdata.
    down_cmp = 1'b0;
    if (sts_o.has_left && (kb_q < ka_q)) begin
      down_cmp = 1'b1;
    end
    if (sts_o.has_right && rb_q) begin
      if (sts_o.has_left && (kb_q < ka_q)) begin
        down_cmp = 1'b1;
      end else if (rdata < ka_q) begin
        down_cmp = 1'b1;
      end
    end
  end

  assign sts_o.is_full   = (cnt_q >= NW'(Capacity));
  assign sts_o.is_empty  = (cnt_q == '0);
  assign sts_o.at_root   = (pos_q == '0);
  assign sts_o.up_swap   = (rdata > ka_q);
  assign sts_o.has_left  = (left < cnt_q);
  assign sts_o.has_right = (right < cnt_q);
  assign sts_o.down_swap = down_cmp;
  assign sts_o.bld_last  = (bld_q == '0);
  assign sts_o.op        = op_q;

  // Result register is loaded from the root read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
      bld_q <= '0;
      op_q  <= bmhq_pkg::OP_INSERT;
      st_q  <= '0;
      rb_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      bld_q <= bld_d;
      op_q  <= op_d;
      st_q  <= st_d;
      rb_q  <= rb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    key_q <= key_d;
    ka_q  <= ka_d;
    kb_q  <= kb_d;
    tk_q  <= tk_d;
    if (ctl_i.cmd == bmhq_pkg::DP_DONE) begin
      taken_key_o   <= tk_q;
      min_key_o     <= (cnt_q == '0) ? '0 : rdata;
      entry_count_o <= bmhq_pkg::CountWidth'(cnt_q);
      status_o      <= st_q;
    end else if (ctl_i.cmd == bmhq_pkg::DP_RD_ROOT) begin
      min_key_o     <= min_key_o;
    end
  end

  // min_key_o also tracks the root so extract can report the removed key.
  // It holds the previous result's root, which equals the current root.

  cnt_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(Capacity))
    else $error("heap count exceeds capacity");
  swap_in_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.cmd == bmhq_pkg::DP_SWAP_2) |-> (tgt_q < cnt_q))
    else $error("swap target outside held entries");
  full_no_grow_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.cmd == bmhq_pkg::DP_APPEND && cnt_q >= NW'(Capacity)) |=> $stable(cnt_q))
    else $error("count changed on full add");

endmodule
`default_nettype wire

>>> rtl/bmhq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Controller state machine: handshakes and sequences datapath commands.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bmhq_pkg::dp_ctl_t      ctl_o,
  input  wire bmhq_pkg::dp_sts_t sts_i
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DISP   = 12'b000000000010,
    S_ROOTW  = 12'b000000000100,
    S_RDA    = 12'b000000001000,
    S_RDB    = 12'b000000010000,
    S_UPCHK  = 12'b000000100000,
    S_RDC    = 12'b000001000000,
    S_DNCHK  = 12'b000010000000,
    S_SWAP2  = 12'b000100000000,
    S_BNEXT  = 12'b001000000000,
    S_ROOT   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic   busy_out;

  assign busy_out   = out_valid_o && out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || busy_out;

  // Sequencer for one operation.
  always_comb begin
    state_d   = state_q;
    ctl_o.cmd = bmhq_pkg::DP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          ctl_o.cmd = bmhq_pkg::DP_START;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.op)
          bmhq_pkg::OP_INSERT: begin
            ctl_o.cmd = bmhq_pkg::DP_APPEND;
            state_d   = sts_i.is_full ? S_ROOT : S_RDA;
          end
          bmhq_pkg::OP_APPEND: begin
            ctl_o.cmd = bmhq_pkg::DP_APPEND;
            state_d   = S_ROOT;
          end
          bmhq_pkg::OP_EXTRACT: begin
            ctl_o.cmd = bmhq_pkg::DP_RD_LAST;
            state_d   = sts_i.is_empty ? S_ROOT : S_ROOTW;
          end
          default: begin
            ctl_o.cmd = bmhq_pkg::DP_BLD_INIT;
            state_d   = S_RDA;
          end
        endcase
      end
      S_ROOTW: begin
        ctl_o.cmd = bmhq_pkg::DP_ROOT_WR;
        state_d   = S_RDA;
      end
      S_RDA: begin
        if (sts_i.op == bmhq_pkg::OP_INSERT && sts_i.at_root) begin
          state_d = S_ROOT;
        end else if (sts_i.op != bmhq_pkg::OP_INSERT && !sts_i.has_left) begin
          state_d = (sts_i.op == bmhq_pkg::OP_BUILD) ? S_BNEXT : S_ROOT;
        end else begin
          ctl_o.cmd = bmhq_pkg::DP_RD_A;
          state_d   = S_RDB;
        end
      end
      S_RDB: begin
        ctl_o.cmd = bmhq_pkg::DP_RD_B;
        state_d   = (sts_i.op == bmhq_pkg::OP_INSERT) ? S_UPCHK : S_RDC;
      end
      S_UPCHK: begin
        if (sts_i.up_swap) begin
          ctl_o.cmd = bmhq_pkg::DP_SWAP_1;
          state_d   = S_SWAP2;
        end else begin
          state_d = S_ROOT;
        end
      end
      S_RDC: begin
        ctl_o.cmd = bmhq_pkg::DP_RD_C;
        state_d   = S_DNCHK;
      end
      S_DNCHK: begin
        if (sts_i.down_swap) begin
          ctl_o.cmd = bmhq_pkg::DP_SWAP_1;
          state_d   = S_SWAP2;
        end else begin
          state_d = (sts_i.op == bmhq_pkg::OP_BUILD) ? S_BNEXT : S_ROOT;
        end
      end
      S_SWAP2: begin
        ctl_o.cmd = bmhq_pkg::DP_SWAP_2;
        state_d   = S_RDA;
      end
      S_BNEXT: begin
        if (sts_i.bld_last) begin
          state_d = S_ROOT;
        end else begin
          ctl_o.cmd = bmhq_pkg::DP_BLD_NEXT;
          state_d   = S_RDA;
        end
      end
      S_ROOT: begin
        ctl_o.cmd = bmhq_pkg::DP_RD_ROOT;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!busy_out) begin
          ctl_o.cmd = bmhq_pkg::DP_DONE;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl_o.cmd == bmhq_pkg::DP_DONE) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  onehot_a: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state not one-hot");
  accept_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DISP))
    else $error("accepted item did not start");
  done_out_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.cmd == bmhq_pkg::DP_DONE) |=> out_valid_o)
    else $error("result not presented");

endmodule
`default_nettype wire

>>> rtl/binary_min_heap_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Array-backed binary min-heap of unsigned keys with one result per item.
// ----------------------------------------------------------------------------
// One item is worked at a time. The store is a single-port RAM, so each sift
// level is a sequence of reads and writes on that port: insert sifts up and
// extract sifts down over up to log2(CAPACITY) levels; build sifts down each
// of count/2+1 nodes. The single RAM port sets the pace.
// A finished result waits in the output register while the next item is
// accepted only after it has been taken or is being taken.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      func_i,
  input  wire logic [KEY_WIDTH-1:0]            key_in_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [KEY_WIDTH-1:0]            taken_key_o,
  output logic      [KEY_WIDTH-1:0]            min_key_o,
  output logic      [bmhq_pkg::CountWidth-1:0] entry_count_o,
  output logic      [1:0]                      status_o
);

  bmhq_pkg::dp_ctl_t ctl;
  bmhq_pkg::dp_sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  bmhq_datapath #(.Capacity(CAPACITY), .KeyWidth(KEY_WIDTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .func_i        (func_i),
    .key_in_i      (key_in_i),
    .taken_key_o   (taken_key_o),
    .min_key_o     (min_key_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

endmodule
`default_nettype wire

>>> dv/binary_min_heap_queue_checker.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_checker
// Watches both channels of the heap queue, keeps its own copy of the heap,
// predicts each result and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_checker #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_i,
  input  wire logic [1:0]                      func_i,
  input  wire logic [KEY_WIDTH-1:0]            key_in_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_stall_i,
  input  wire logic [KEY_WIDTH-1:0]            taken_key_i,
  input  wire logic [KEY_WIDTH-1:0]            min_key_i,
  input  wire logic [bmhq_pkg::CountWidth-1:0] entry_count_i,
  input  wire logic [1:0]                      status_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);

  typedef struct packed {
    logic [KEY_WIDTH-1:0]            taken;
    logic [KEY_WIDTH-1:0]            min;
    logic [bmhq_pkg::CountWidth-1:0] count;
    bmhq_pkg::status_e               status;
  } heap_result_t;

  logic [KEY_WIDTH-1:0] heap_keys [CAPACITY];
  int unsigned          heap_size;
  heap_result_t         result_queue [$];

  assign pending_o = result_queue.size();

  // Move the entry at pos down toward its smaller child, the left one on a tie.
  function automatic void sift_down_at(int unsigned pos);
    int unsigned lc, rc, best;
    logic [KEY_WIDTH-1:0] tmp;
    forever begin
      lc   = 2 * pos + 1;
      rc   = 2 * pos + 2;
      best = pos;
      if (lc < heap_size && heap_keys[lc] < heap_keys[best]) best = lc;
      if (rc < heap_size && heap_keys[rc] < heap_keys[best]) best = rc;
      if (best == pos) return;
      tmp = heap_keys[pos];
      heap_keys[pos] = heap_keys[best];
      heap_keys[best] = tmp;
      pos = best;
    end
  endfunction

  // Apply one operation to the shadow heap and return what the block reports.
  function automatic heap_result_t apply_heap_op(bmhq_pkg::op_e op,
                                                 logic [KEY_WIDTH-1:0] key);
    heap_result_t r;
    int unsigned pos, up, idx;
    logic [KEY_WIDTH-1:0] tmp;
    r = '0;
    r.status = bmhq_pkg::ST_OK;
    case (op)
      bmhq_pkg::OP_INSERT, bmhq_pkg::OP_APPEND: begin
        if (heap_size >= CAPACITY) begin
          r.status = bmhq_pkg::ST_FULL;
        end else begin
          pos = heap_size;
          heap_keys[pos] = key;
          heap_size++;
          if (op == bmhq_pkg::OP_INSERT) begin
            while (pos != 0) begin
              up = (pos - 1) / 2;
              if (!(heap_keys[up] > heap_keys[pos])) break;
              tmp = heap_keys[up];
              heap_keys[up] = heap_keys[pos];
              heap_keys[pos] = tmp;
              pos = up;
            end
          end
        end
      end
      bmhq_pkg::OP_EXTRACT: begin
        if (heap_size == 0) begin
          r.status = bmhq_pkg::ST_EMPTY;
        end else begin
          r.taken = heap_keys[0];
          heap_size--;
          heap_keys[0] = heap_keys[heap_size];
          sift_down_at(0);
        end
      end
      default: begin
        idx = heap_size / 2 + 1;
        while (idx > 0) begin
          idx--;
          sift_down_at(idx);
        end
      end
    endcase
    r.min   = (heap_size > 0) ? heap_keys[0] : '0;
    r.count = heap_size[bmhq_pkg::CountWidth-1:0];
    return r;
  endfunction

  // Predict on each accepted input transaction, compare each output one.
  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    if (!rst_ni) begin
      heap_size    = 0;
      fail_count_o = 0;
      result_queue.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("Unexpected result transaction: taken %h min %h count %0d status %0d",
                     taken_key_i, min_key_i, entry_count_i, status_i);
        end else begin
          want = result_queue.pop_front();
          if (taken_key_i !== want.taken || min_key_i !== want.min ||
              entry_count_i !== want.count || status_i !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("Mismatch: exp %h %h %0d %0d, got %h %h %0d %0d",
                       want.taken, want.min, want.count, want.status,
                       taken_key_i, min_key_i, entry_count_i, status_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        result_queue.push_back(apply_heap_op(bmhq_pkg::op_e'(func_i), key_in_i));
    end
  end

endmodule

>>> dv/binary_min_heap_queue_tb.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb
// Drives directed and random heap operations with random gaps and stalls;
// the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;

  localparam int unsigned Capacity  = 1024;
  localparam int unsigned KeyWidth  = 32;
  localparam int          IdleLimit = 200000;

  logic                            clk_i, rst_ni;
  logic                            in_valid_i, in_stall_o;
  logic [1:0]                      func_i;
  logic [KeyWidth-1:0]             key_in_i;
  logic                            out_valid_o, out_stall_i;
  logic [KeyWidth-1:0]             taken_key_o, min_key_o;
  logic [bmhq_pkg::CountWidth-1:0] entry_count_o;
  logic [1:0]                      status_o;
  int                              fail_count, pending;
  int                              idle_cycles;
  int unsigned                     model_count;
  bit                              in_burst, out_burst;

  binary_min_heap_queue #(.CAPACITY(Capacity), .KEY_WIDTH(KeyWidth)) dut (.*);

  binary_min_heap_queue_checker #(.CAPACITY(Capacity), .KEY_WIDTH(KeyWidth)) checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .func_i, .key_in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .taken_key_i(taken_key_o),
    .min_key_i(min_key_o), .entry_count_i(entry_count_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(60, 10);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3);
  endfunction

  // Random key drawn from narrow and full ranges so that ties and extremes occur.
  function automatic logic [KeyWidth-1:0] pick_key();
    case ($urandom_range(4))
      0:       return $urandom_range(7);
      1:       return 32'hFFFF_FFFF - $urandom_range(3);
      2:       return $urandom_range(255);
      default: return $urandom();
    endcase
  endfunction

  // Present one input transaction and hold it until it is accepted. Valid
  // drops only when a gap follows, so back-to-back items keep it high.
  task automatic send_op(bmhq_pkg::op_e op, logic [KeyWidth-1:0] key);
    int gap;
    gap = in_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    key_in_i   <= key;
    do @(posedge clk_i); while (in_stall_o);
    if ((op == bmhq_pkg::OP_INSERT || op == bmhq_pkg::OP_APPEND) && model_count < Capacity)
      model_count++;
    if (op == bmhq_pkg::OP_EXTRACT && model_count > 0) model_count--;
  endtask

  // Receiver stalls at random, with stretches of no stalling.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(199) == 0) out_burst <= ~out_burst;
      if (out_burst) out_stall_i <= 1'b0;
      else if ($urandom_range(29) == 0) out_stall_i <= 1'b1;
      else if ($urandom_range(2) == 0) out_stall_i <= ~out_stall_i;
    end
  end

  // Cycles without any accepted transaction end the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("binary_min_heap_queue test failed");
        $finish;
      end
    end
  end

  initial begin
    int r, burst_len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    func_i      = bmhq_pkg::OP_INSERT;
    key_in_i    = '0;
    in_burst    = 1'b0;
    out_burst   = 1'b0;
    model_count = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cases, extremes, ties, every operation.
    send_op(bmhq_pkg::OP_EXTRACT, 32'hFFFF_FFFF);
    send_op(bmhq_pkg::OP_BUILD, '0);
    send_op(bmhq_pkg::OP_INSERT, 32'hFFFF_FFFF);
    send_op(bmhq_pkg::OP_BUILD, '0);
    send_op(bmhq_pkg::OP_INSERT, '0);
    send_op(bmhq_pkg::OP_INSERT, 32'd5);
    send_op(bmhq_pkg::OP_INSERT, 32'd5);
    send_op(bmhq_pkg::OP_INSERT, '0);
    send_op(bmhq_pkg::OP_EXTRACT, '0);
    send_op(bmhq_pkg::OP_EXTRACT, '0);
    send_op(bmhq_pkg::OP_APPEND, 32'd9);
    send_op(bmhq_pkg::OP_APPEND, 32'd1);
    send_op(bmhq_pkg::OP_APPEND, 32'd1);
    send_op(bmhq_pkg::OP_APPEND, 32'hAAAA_5555);
    send_op(bmhq_pkg::OP_APPEND, 32'h5555_AAAA);
    send_op(bmhq_pkg::OP_BUILD, '0);
    repeat (6) send_op(bmhq_pkg::OP_EXTRACT, '0);
    send_op(bmhq_pkg::OP_EXTRACT, '0);

    // Fill to capacity with mixed adds, overflow, build, then drain partly.
    while (model_count < Capacity) begin
      in_burst = 1'b1;
      send_op(bmhq_pkg::op_e'($urandom_range(1) ? bmhq_pkg::OP_APPEND
                                                : bmhq_pkg::OP_INSERT), pick_key());
    end
    in_burst = 1'b0;
    send_op(bmhq_pkg::OP_INSERT, '0);
    send_op(bmhq_pkg::OP_APPEND, 32'hFFFF_FFFF);
    send_op(bmhq_pkg::OP_BUILD, '0);
    repeat (40) send_op(bmhq_pkg::OP_EXTRACT, '0);

    // Random: mostly inserts and extracts, with some appends and builds.
    for (int n = 0; n < 40; n++) begin
      if (burst_len == 0) begin
        in_burst  = ($urandom_range(4) == 0);
        burst_len = $urandom_range(40, 5);
      end
      burst_len--;
      r = $urandom_range(99);
      if (r < 40)      send_op(bmhq_pkg::OP_INSERT, pick_key());
      else if (r < 75) send_op(bmhq_pkg::OP_EXTRACT, pick_key());
      else if (r < 92) send_op(bmhq_pkg::OP_APPEND, pick_key());
      else             send_op(bmhq_pkg::OP_BUILD, pick_key());
    end
    in_burst = 1'b0;
    in_valid_i <= 1'b0;

    // Drain and let the block settle before the verdict.
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("binary_min_heap_queue test passed");
    else
      $display("binary_min_heap_queue test failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/bmhq_datapath.sv
rtl/bmhq_ctrl.sv
rtl/binary_min_heap_queue.sv
dv/binary_min_heap_queue_checker.sv
dv/binary_min_heap_queue_tb.sv
